// ===== rtl/ttc_emergency_brake_decider_macros.svh =====
// Assertion macros shared by the emergency brake decider RTL.
// Needs clk and rst in the scope of each use.
`ifndef TTC_EMERGENCY_BRAKE_DECIDER_MACROS_SVH
`define TTC_EMERGENCY_BRAKE_DECIDER_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define TTCEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define TTCEB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttceb_pkg.sv =====
// Shared widths, constants, register codes and word types for the
// emergency brake decider. No dependencies.
package ttceb_pkg;

  // Field widths
  localparam int DIST_W    = 16;
  localparam int SPEED_W   = 14;
  localparam int GEAR_W    = 4;
  localparam int BRAKE_W   = 8;
  localparam int CLEAR_W   = 10;
  localparam int TTC_W     = 12;
  localparam int RATE_W    = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int DELTA_W = DIST_W + 1;
  localparam int APPR_W  = DELTA_W + RATE_W + 1;
  localparam int CLOSE_W = DIST_W + RATE_W;
  localparam int LHS_W   = DIST_W + 10;
  localparam int RHS_W   = TTC_W + CLOSE_W;

  // Constants
  localparam int MS_PER_S       = 1000;
  localparam int SLOW_SPEED_CMS = 10;

  localparam logic [BRAKE_W-1:0] BRAKE_DIST_RST = BRAKE_W'(20);
  localparam logic [CLEAR_W-1:0] CLEAR_DIST_RST = CLEAR_W'(100);
  localparam logic [TTC_W-1:0]   TTC_LIMIT_RST  = TTC_W'(350);
  localparam logic [RATE_W-1:0]  RATE_SCALE_RST = RATE_W'(50);
  localparam logic [GEAR_W-1:0]  REV_GEAR_RST   = GEAR_W'(2);
  localparam logic [DIST_W-1:0]  PREV_DIST_RST  = DIST_W'(80);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRAKE_DIST = 3'd0,
    REG_CLEAR_DIST = 3'd1,
    REG_TTC_LIMIT  = 3'd2,
    REG_RATE_SCALE = 3'd3,
    REG_REV_GEAR   = 3'd4
  } ttceb_reg_t;

  typedef struct packed {
    logic [BRAKE_W-1:0] brake_dist_cm;
    logic [CLEAR_W-1:0] clear_range_cm;
    logic [TTC_W-1:0]   ttc_limit_ms;
    logic [RATE_W-1:0]  rate_scale;
    logic [GEAR_W-1:0]  reverse_gear_code;
  } ttceb_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  range_cm;
    logic               auto_brake_en;
    logic               brake_active;
    logic [GEAR_W-1:0]  gear_code;
    logic [SPEED_W-1:0] speed_cms;
  } ttceb_in_t;

  typedef struct packed {
    logic cmd_valid;
    logic brake_cmd;
  } ttceb_out_t;

  // Word after screening and approach-rate multiply
  typedef struct packed {
    logic                     braking;
    logic                     decided;
    logic                     action;
    logic                     le_brake;
    logic [DIST_W-1:0]        range_cm;
    logic [SPEED_W-1:0]       speed;
    logic signed [APPR_W-1:0] approach;
  } ttceb_s1_t;

  // Word after the time-to-collision products
  typedef struct packed {
    logic              braking;
    logic              decided;
    logic              action;
    logic              le_brake;
    logic [LHS_W-1:0]  lhs;
    logic [RHS_W-1:0]  rhs;
  } ttceb_s2_t;

endpackage

// ===== rtl/ttc_emergency_brake_decider.sv =====
// Channel   | handshake           | word
// ----------+---------------------+----------------------------------------
// input     | in_valid / in_ready | in_data: distance, enable, brake, gear, speed
// output    | out_valid/out_ready | out_data: cmd_valid, brake_cmd
// config    | cfg_we              | cfg_index, cfg_data (write only)
//
// One word per cycle sustained while out_ready stays high. An accepted word
// passes through three registers (screen/approach multiply, TTC multiply,
// output register) before out_valid rises. Each stage advances when the one after
// it is empty or moving, so bubbles fill while a result waits. rst is synchronous:
// config returns to defaults, the previous distance to 80 cm and all stages empty.
// Top level of the emergency brake decider. Depends on ttceb_pkg,
// ttceb_cfg, ttceb_screen and ttceb_ttc.
module ttc_emergency_brake_decider import ttceb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttceb_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttceb_out_t           out_data
);

  ttceb_cfg_t cfg;
  logic       s1_valid;
  logic       s1_ready;
  ttceb_s1_t  s1;

  // Configuration registers
  ttceb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Early exits and approach rate
  ttceb_screen u_screen (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  // TTC compare and result register
  ttceb_ttc u_ttc (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/ttceb_cfg.sv =====
// Configuration register file for the emergency brake decider.
// Depends on ttceb_pkg.
module ttceb_cfg import ttceb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output ttceb_cfg_t           cfg
);

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_dist_cm     <= BRAKE_DIST_RST;
      cfg.clear_range_cm    <= CLEAR_DIST_RST;
      cfg.ttc_limit_ms      <= TTC_LIMIT_RST;
      cfg.rate_scale        <= RATE_SCALE_RST;
      cfg.reverse_gear_code <= REV_GEAR_RST;
    end else if (cfg_we) begin
      unique case (ttceb_reg_t'(cfg_index))
        REG_BRAKE_DIST: cfg.brake_dist_cm     <= cfg_data[BRAKE_W-1:0];
        REG_CLEAR_DIST: cfg.clear_range_cm    <= cfg_data[CLEAR_W-1:0];
        REG_TTC_LIMIT:  cfg.ttc_limit_ms      <= cfg_data[TTC_W-1:0];
        REG_RATE_SCALE: cfg.rate_scale        <= cfg_data[RATE_W-1:0];
        REG_REV_GEAR:   cfg.reverse_gear_code <= cfg_data[GEAR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ttceb_screen.sv =====
// Front stage: previous distance, early-exit decisions and approach-rate
// multiply. Depends on ttceb_pkg and the assertion macro header.
`include "ttc_emergency_brake_decider_macros.svh"

module ttceb_screen import ttceb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ttceb_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  ttceb_in_t  in_data,
  output logic       s1_valid,
  input  logic       s1_ready,
  output ttceb_s1_t  s1
);

  logic [DIST_W-1:0]        prev_distance;
  logic                     accept;
  logic signed [DELTA_W-1:0] delta;
  logic                     near_zero;
  logic signed [APPR_W-1:0] approach;
  logic                     dist_zero;
  logic                     le_brake;
  logic                     gt_clear;
  logic                     is_rev;
  logic                     slow;
  logic                     decided;
  logic                     action;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // Signed distance change since the last sample
  assign delta = $signed({1'b0, prev_distance}) - $signed({1'b0, in_data.range_cm});
  assign near_zero = (delta == '0) || (delta == DELTA_W'(1)) || (delta == '1);

  // Approach rate in cm/s, zero when the change is within one
  assign approach = near_zero ? '0 :
                    APPR_W'(delta) * APPR_W'($signed({1'b0, cfg.rate_scale}));

  // Threshold compares
  assign dist_zero = (in_data.range_cm == '0);
  assign le_brake  = (in_data.range_cm <= DIST_W'(cfg.brake_dist_cm));
  assign gt_clear  = (in_data.range_cm > DIST_W'(cfg.clear_range_cm));
  assign is_rev    = (in_data.gear_code == cfg.reverse_gear_code);
  assign slow      = (in_data.speed_cms <= SPEED_W'(SLOW_SPEED_CMS));

  // Early exits, first match wins
  always_comb begin
    decided = 1'b1;
    action  = 1'b0;
    if (!in_data.auto_brake_en) begin
      action = 1'b0;
    end else if (in_data.brake_active && le_brake && !dist_zero && !is_rev) begin
      action = 1'b1;
    end else if (gt_clear || dist_zero || is_rev || slow) begin
      action = 1'b0;
    end else begin
      decided = 1'b0;
    end
  end

  // Remember the accepted distance
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_distance <= PREV_DIST_RST;
    end else if (accept) begin
      prev_distance <= in_data.range_cm;
    end
  end

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.braking  <= in_data.brake_active;
      s1.decided  <= decided;
      s1.action   <= action;
      s1.le_brake <= le_brake;
      s1.range_cm <= in_data.range_cm;
      s1.speed    <= in_data.speed_cms;
      s1.approach <= approach;
    end
  end

  `TTCEB_ASSERT_NEXT(a_prev_tracks, accept, prev_distance == $past(in_data.range_cm), "prev lost")
  `TTCEB_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_ready, s1_valid && $stable(s1), "s1 lost")

endmodule

// ===== rtl/ttceb_ttc.sv =====
// Back stages: closing speed, time-to-collision cross-multiply, final
// decision and output register. Depends on ttceb_pkg and the macro header.
`include "ttc_emergency_brake_decider_macros.svh"

module ttceb_ttc import ttceb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ttceb_cfg_t cfg,
  input  logic       s1_valid,
  output logic       s1_ready,
  input  ttceb_s1_t  s1,
  output logic       out_valid,
  input  logic       out_ready,
  output ttceb_out_t out_data
);

  logic              s2_valid;
  ttceb_s2_t         s2;
  logic              out_free;
  logic [CLOSE_W-1:0] closing;
  logic [RHS_W-1:0]  rhs;
  logic [LHS_W-1:0]  lhs;
  logic              hit;
  logic              action;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s2_valid || out_free;

  // Closing speed is the larger of approach rate and vehicle speed
  assign closing = (s1.approach > $signed(APPR_W'(s1.speed))) ?
                   s1.approach[CLOSE_W-1:0] : CLOSE_W'(s1.speed);

  // Cross-multiplied TTC compare operands
  assign rhs = RHS_W'(cfg.ttc_limit_ms) * RHS_W'(closing);
  assign lhs = LHS_W'(s1.range_cm) * LHS_W'(MS_PER_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2.braking  <= s1.braking;
      s2.decided  <= s1.decided;
      s2.action   <= s1.action;
      s2.le_brake <= s1.le_brake;
      s2.lhs      <= lhs;
      s2.rhs      <= rhs;
    end
  end

  // Final decision
  assign hit    = (RHS_W'(s2.lhs) < s2.rhs) || s2.le_brake;
  assign action = s2.decided ? s2.action : hit;

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      out_data.cmd_valid <= action || s2.braking;
      out_data.brake_cmd <= action;
    end
  end

  `TTCEB_ASSERT_NOW(a_cmd_flag, out_valid && out_data.brake_cmd, out_data.cmd_valid, "no cmd")
  `TTCEB_ASSERT_NEXT(a_s2_hold, s2_valid && !out_free, s2_valid && $stable(s2), "s2 lost")

endmodule
